// ===== rtl/ogru_pkg.sv =====
// Shared types and constants of the occupancy grid ray update block.
package ogru_pkg;

    localparam int COORD_BITS     = 8;
    localparam int LOG_ODDS_BITS  = 16;
    localparam int COUNT_BITS     = 9;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIT_STEP       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MISS_STEP      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLAMP_HIGH     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLAMP_LOW      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FREE_BELOW     = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OCCUPIED_ABOVE = 3'd7;

    // Operation codes.
    localparam logic OP_TRACE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Occupancy classes.
    localparam logic [1:0] CLASS_FREE     = 2'd0;
    localparam logic [1:0] CLASS_OCCUPIED = 2'd1;
    localparam logic [1:0] CLASS_UNKNOWN  = 2'd2;

    typedef struct packed {
        logic        [10:0] hit_step;
        logic signed [11:0] miss_step;
        logic        [14:0] clamp_high;
        logic signed [15:0] clamp_low;
        logic        [8:0]  grid_width;
        logic        [8:0]  grid_height;
        logic signed [15:0] free_below;
        logic signed [15:0] occupied_above;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic reject;
        logic issue;
        logic hit_sel;
        logic advance;
        logic capture;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic op_read;
        logic start_in;
        logic end_in;
        logic at_end;
        logic hit_flag;
    } stat_t;

endpackage

// ===== rtl/occupancy_grid_ray_update.sv =====
// Top level of the occupancy grid ray update block: configuration registers and instances.
//
// After reset the block clears its grid memory, one cell a cycle, all
// GRID_SIDE*GRID_SIDE cells (65536 by default) with busy high; configuration
// writes are taken throughout. An item is transferred when start is high and
// busy low. The result appears for exactly one cycle with done high, and must
// be taken then, since the receiver cannot hold it off. A read goes from the
// decode state through the read state to done, a rejected item from decode
// straight to done. A trace walking n cells (n = max(|dx|,|dy|)+1) goes
// through the walk and drain states to done: the walker visits one cell a
// cycle, reading it through the grid memory's read port while the cell before
// it is written back through the write port. busy falls in the cycle after done.
module occupancy_grid_ray_update
    import ogru_pkg::*;
#(
    parameter int GRID_SIDE = 256,
    parameter int CELL_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            operation,
    input  logic [COORD_BITS-1:0]           start_col,
    input  logic [COORD_BITS-1:0]           start_row,
    input  logic [COORD_BITS-1:0]           end_col,
    input  logic [COORD_BITS-1:0]           end_row,
    input  logic                            endpoint_is_hit,
    output logic                            done,
    output logic signed [LOG_ODDS_BITS-1:0] cell_log_odds,
    output logic [1:0]                      occupancy_class,
    output logic [COUNT_BITS-1:0]           cells_updated,
    output logic                            status,
    input  logic                            wr_en,
    input  logic [CFG_INDEX_BITS-1:0]       wr_index,
    input  logic [CFG_DATA_BITS-1:0]        wr_data
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hit_step       <= 11'd217;
            cfg_reg.miss_step      <= -12'sd104;
            cfg_reg.clamp_high     <= 15'd1280;
            cfg_reg.clamp_low      <= -16'sd1280;
            cfg_reg.grid_width     <= 9'd256;
            cfg_reg.grid_height    <= 9'd256;
            cfg_reg.free_below     <= -16'sd281;
            cfg_reg.occupied_above <= 16'sd158;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HIT_STEP:       cfg_reg.hit_step       <= wr_data[10:0];
                REG_MISS_STEP:      cfg_reg.miss_step      <= wr_data[11:0];
                REG_CLAMP_HIGH:     cfg_reg.clamp_high     <= wr_data[14:0];
                REG_CLAMP_LOW:      cfg_reg.clamp_low      <= wr_data;
                REG_GRID_WIDTH:     cfg_reg.grid_width     <= wr_data[8:0];
                REG_GRID_HEIGHT:    cfg_reg.grid_height    <= wr_data[8:0];
                REG_FREE_BELOW:     cfg_reg.free_below     <= wr_data;
                REG_OCCUPIED_ABOVE: cfg_reg.occupied_above <= wr_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    ogru_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ogru_datapath #(
        .GRID_SIDE (GRID_SIDE),
        .CELL_BITS (CELL_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg             (cfg_reg),
        .operation       (operation),
        .start_col       (start_col),
        .start_row       (start_row),
        .end_col         (end_col),
        .end_row         (end_row),
        .endpoint_is_hit (endpoint_is_hit),
        .stat            (stat),
        .cell_log_odds   (cell_log_odds),
        .occupancy_class (occupancy_class),
        .cells_updated   (cells_updated),
        .status          (status)
    );

endmodule

// ===== rtl/ogru_ram.sv =====
// Generic RAM with one write port and one registered read port.
module ogru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ogru_ctrl.sv =====
// Controller state machine of the occupancy grid ray update block.
module ogru_ctrl
    import ogru_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.op_read)
                begin
                    state_next = stat.start_in ? ST_READ : ST_DONE;
                end
                else
                begin
                    state_next = (stat.start_in && stat.end_in) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (stat.at_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DECODE:
            begin
                if (stat.op_read)
                begin
                    cmd.reject = !stat.start_in;
                end
                else
                begin
                    cmd.reject = !(stat.start_in && stat.end_in);
                end
            end
            ST_WALK:
            begin
                // The end cell is read only when a hit is to be applied to it.
                if (stat.at_end)
                begin
                    cmd.issue   = stat.hit_flag;
                    cmd.hit_sel = 1'b1;
                end
                else
                begin
                    cmd.issue   = 1'b1;
                    cmd.advance = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/ogru_datapath.sv =====
// Datapath: ray walker, grid memory, cell update pipeline and result registers.
module ogru_datapath
    import ogru_pkg::*;
#(
    parameter int GRID_SIDE = 256,
    parameter int CELL_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    input  cfg_t                      cfg,
    input  logic                      operation,
    input  logic [COORD_BITS-1:0]     start_col,
    input  logic [COORD_BITS-1:0]     start_row,
    input  logic [COORD_BITS-1:0]     end_col,
    input  logic [COORD_BITS-1:0]     end_row,
    input  logic                      endpoint_is_hit,
    output stat_t                     stat,
    output logic signed [LOG_ODDS_BITS-1:0] cell_log_odds,
    output logic [1:0]                occupancy_class,
    output logic [COUNT_BITS-1:0]     cells_updated,
    output logic                      status
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (CELL_BITS + 2 > 17) ? CELL_BITS + 2 : 17;
    localparam int ERR_W  = COORD_BITS + 3;

    localparam logic signed [CMP_W-1:0] CELL_MAX =
        {{(CMP_W-CELL_BITS+1){1'b0}}, {(CELL_BITS-1){1'b1}}};
    localparam logic signed [CMP_W-1:0] CELL_MIN = ~CELL_MAX;
    localparam logic signed [CMP_W-1:0] OUT_MAX  = CMP_W'(32767);
    localparam logic signed [CMP_W-1:0] OUT_MIN  = CMP_W'(-32768);

    function automatic logic in_range(input logic [COORD_BITS-1:0] coord,
                                      input logic [8:0] limit);
        logic [31:0] c32;
        c32 = 32'(coord);
        return (c32 < 32'(limit)) && (c32 < 32'(GRID_SIDE));
    endfunction

    logic                     op_reg;
    logic                     hit_reg;
    logic                     start_in_reg;
    logic                     end_in_reg;
    logic [COORD_BITS-1:0]    cur_c_reg;
    logic [COORD_BITS-1:0]    cur_r_reg;
    logic [COORD_BITS-1:0]    end_c_reg;
    logic [COORD_BITS-1:0]    end_r_reg;
    logic [COORD_BITS-1:0]    dx_reg;
    logic [COORD_BITS-1:0]    dy_reg;
    logic                     c_up_reg;
    logic                     r_up_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic                     s1_valid_reg;
    logic                     s1_hit_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic signed [LOG_ODDS_BITS-1:0] res_log_odds_reg;
    logic [1:0]               res_class_reg;
    logic [COUNT_BITS-1:0]    res_count_reg;
    logic                     res_status_reg;

    logic [COORD_BITS-1:0]    dx_in;
    logic [COORD_BITS-1:0]    dy_in;
    logic signed [ERR_W-1:0]  err_in;
    logic signed [ERR_W:0]    e2;
    logic                     move_c;
    logic                     move_r;
    logic signed [ERR_W-1:0]  err_next;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CELL_BITS-1:0]     rdata;
    logic signed [CMP_W-1:0]  old_val;
    logic signed [CMP_W-1:0]  step_val;
    logic signed [CMP_W-1:0]  sum_val;
    logic signed [CMP_W-1:0]  hi_val;
    logic signed [CMP_W-1:0]  lo_val;
    logic signed [CMP_W-1:0]  v1;
    logic signed [CMP_W-1:0]  v2;
    logic signed [CMP_W-1:0]  v3;
    logic signed [CMP_W-1:0]  new_val;
    logic                     changed;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [CELL_BITS-1:0]     ram_wdata;
    logic [1:0]               rd_class;
    logic signed [CMP_W-1:0]  rd_sat;

    // Line set-up from the input ports at the transfer.
    assign dx_in  = (end_col > start_col) ? end_col - start_col : start_col - end_col;
    assign dy_in  = (end_row > start_row) ? end_row - start_row : start_row - end_row;
    assign err_in = $signed(ERR_W'(dx_in)) - $signed(ERR_W'(dy_in));

    // One Bresenham step; both decisions use the error before the step.
    assign e2       = {err_reg, 1'b0};
    assign move_c   = e2 > -$signed((ERR_W+1)'(dy_reg));
    assign move_r   = e2 < $signed((ERR_W+1)'(dx_reg));
    assign err_next = err_reg - (move_c ? $signed(ERR_W'(dy_reg)) : '0)
                              + (move_r ? $signed(ERR_W'(dx_reg)) : '0);

    assign rd_addr = ADDR_W'(cur_r_reg) * ADDR_W'(GRID_SIDE) + ADDR_W'(cur_c_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= operation;
            hit_reg      <= endpoint_is_hit;
            start_in_reg <= in_range(start_col, cfg.grid_width)
                            && in_range(start_row, cfg.grid_height);
            end_in_reg   <= in_range(end_col, cfg.grid_width)
                            && in_range(end_row, cfg.grid_height);
            cur_c_reg    <= start_col;
            cur_r_reg    <= start_row;
            end_c_reg    <= end_col;
            end_r_reg    <= end_row;
            dx_reg       <= dx_in;
            dy_reg       <= dy_in;
            c_up_reg     <= start_col < end_col;
            r_up_reg     <= start_row < end_row;
            err_reg      <= err_in;
        end
        else if (cmd.advance)
        begin
            if (move_c)
            begin
                cur_c_reg <= c_up_reg ? cur_c_reg + 1'b1 : cur_c_reg - 1'b1;
            end
            if (move_r)
            begin
                cur_r_reg <= r_up_reg ? cur_r_reg + 1'b1 : cur_r_reg - 1'b1;
            end
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hit_reg  <= cmd.hit_sel;
        s1_addr_reg <= rd_addr;
    end

    // Read-modify-write of the cell read in the previous cycle.
    assign old_val  = CMP_W'($signed(rdata));
    assign step_val = s1_hit_reg ? CMP_W'($signed({1'b0, cfg.hit_step}))
                                 : CMP_W'($signed(cfg.miss_step));
    assign sum_val  = old_val + step_val;
    assign hi_val   = CMP_W'($signed({1'b0, cfg.clamp_high}));
    assign lo_val   = CMP_W'($signed(cfg.clamp_low));
    assign v1       = (sum_val > hi_val) ? hi_val : sum_val;
    assign v2       = (v1 < lo_val) ? lo_val : v1;
    assign v3       = (v2 > CELL_MAX) ? CELL_MAX : v2;
    assign new_val  = (v3 < CELL_MIN) ? CELL_MIN : v3;
    assign changed  = new_val != old_val;

    assign ram_we    = cmd.clear || s1_valid_reg;
    assign ram_waddr = cmd.clear ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = cmd.clear ? '0 : new_val[CELL_BITS-1:0];

    ogru_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // Classification and output saturation of a cell read.
    always_comb
    begin
        if (old_val < CMP_W'($signed(cfg.free_below)))
        begin
            rd_class = CLASS_FREE;
        end
        else if (old_val > CMP_W'($signed(cfg.occupied_above)))
        begin
            rd_class = CLASS_OCCUPIED;
        end
        else
        begin
            rd_class = CLASS_UNKNOWN;
        end
        if (old_val > OUT_MAX)
        begin
            rd_sat = OUT_MAX;
        end
        else if (old_val < OUT_MIN)
        begin
            rd_sat = OUT_MIN;
        end
        else
        begin
            rd_sat = old_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_log_odds_reg <= '0;
            res_class_reg    <= CLASS_UNKNOWN;
            res_count_reg    <= '0;
            res_status_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.reject)
            begin
                res_status_reg <= 1'b1;
            end
            if (cmd.capture)
            begin
                res_log_odds_reg <= rd_sat[LOG_ODDS_BITS-1:0];
                res_class_reg    <= rd_class;
            end
            if (s1_valid_reg && changed)
            begin
                res_count_reg <= res_count_reg + 1'b1;
            end
        end
    end

    assign stat.clear_last = clr_addr_reg == ADDR_W'(DEPTH - 1);
    assign stat.op_read    = op_reg == OP_READ;
    assign stat.start_in   = start_in_reg;
    assign stat.end_in     = end_in_reg;
    assign stat.at_end     = (cur_c_reg == end_c_reg) && (cur_r_reg == end_r_reg);
    assign stat.hit_flag   = hit_reg;

    assign cell_log_odds   = res_log_odds_reg;
    assign occupancy_class = res_class_reg;
    assign cells_updated   = res_count_reg;
    assign status          = res_status_reg;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the occupancy grid ray update block: rays and cell reads checked against a grid model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ogru_pkg::*;

    localparam int   SIDE            = 256;
    localparam int   CELL_MAX        = 32767;
    localparam int   CELL_MIN        = -32768;
    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;
    localparam int   WATCHDOG_LIMIT  = 200000;
    localparam int   RANDOM_PHASES   = 6;
    localparam int   ITEMS_PER_PHASE = 200;
    localparam int   MAX_PRINTED     = 100;

    typedef struct packed {
        logic       op;
        logic [7:0] sc;
        logic [7:0] sr;
        logic [7:0] ec;
        logic [7:0] er;
        logic       hit;
    } ray_cmd_t;

    typedef struct packed {
        logic signed [15:0] odds_val;
        logic [1:0]         occ_class;
        logic [8:0]         changed;
        logic               status;
    } cell_report_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            operation = OP_TRACE;
    logic [COORD_BITS-1:0]           start_col = '0;
    logic [COORD_BITS-1:0]           start_row = '0;
    logic [COORD_BITS-1:0]           end_col = '0;
    logic [COORD_BITS-1:0]           end_row = '0;
    logic                            endpoint_is_hit = 1'b0;
    logic                            done;
    logic signed [LOG_ODDS_BITS-1:0] cell_log_odds;
    logic [1:0]                      occupancy_class;
    logic [COUNT_BITS-1:0]           cells_updated;
    logic                            status;
    logic                            wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]       wr_index = '0;
    logic [CFG_DATA_BITS-1:0]        wr_data = '0;

    // Model of the grid and the registers, updated as each transfer is taken.
    logic signed [15:0] odds_map [SIDE*SIDE];
    cfg_t               map_cfg;
    cell_report_t       awaited_reports [$];

    int error_count = 0;
    int traces_sent = 0;
    int reads_sent = 0;
    int rejects_seen = 0;
    int cells_changed = 0;
    int idle_cycles = 0;
    int win_lo = 0;
    int win_span = 8;
    int idle_gap_max = 8;
    int burst_left = 0;
    bit no_idle = 1'b1;

    occupancy_grid_ray_update dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .start_col       (start_col),
        .start_row       (start_row),
        .end_col         (end_col),
        .end_row         (end_row),
        .endpoint_is_hit (endpoint_is_hit),
        .done            (done),
        .cell_log_odds   (cell_log_odds),
        .occupancy_class (occupancy_class),
        .cells_updated   (cells_updated),
        .status          (status),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    function automatic int cols_in_use();
        return (map_cfg.grid_width > 9'd256) ? SIDE : int'(map_cfg.grid_width);
    endfunction

    function automatic int rows_in_use();
        return (map_cfg.grid_height > 9'd256) ? SIDE : int'(map_cfg.grid_height);
    endfunction

    function automatic bit in_grid(input int c, input int r);
        return (c < cols_in_use()) && (r < rows_in_use());
    endfunction

    // Adds a step to one cell with both saturations; gives 1 when the value moved.
    function automatic int bump_cell(input int c, input int r, input int step);
        int old_v;
        int v;
        int hi;
        int lo;
        old_v = odds_map[r*SIDE + c];
        hi = int'(map_cfg.clamp_high);
        lo = $signed(map_cfg.clamp_low);
        v = old_v + step;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        if (v > CELL_MAX) v = CELL_MAX;
        if (v < CELL_MIN) v = CELL_MIN;
        odds_map[r*SIDE + c] = v[15:0];
        return (v != old_v) ? 1 : 0;
    endfunction

    function automatic cell_report_t predict_cmd(input ray_cmd_t cmd);
        cell_report_t rep;
        int sc;
        int sr;
        int ec;
        int er;
        int dx;
        int dy;
        int stx;
        int sty;
        int err;
        int e2;
        int c;
        int r;
        int v;
        int free_lim;
        int occ_lim;
        int hit_inc;
        int miss_inc;
        int count;
        bit walking;
        rep.odds_val = '0;
        rep.occ_class = CLASS_UNKNOWN;
        rep.changed = '0;
        rep.status = STATUS_DONE;
        sc = int'(cmd.sc);
        sr = int'(cmd.sr);
        ec = int'(cmd.ec);
        er = int'(cmd.er);
        count = 0;
        if (cmd.op == OP_READ)
        begin
            if (in_grid(sc, sr))
            begin
                v = odds_map[sr*SIDE + sc];
                free_lim = $signed(map_cfg.free_below);
                occ_lim = $signed(map_cfg.occupied_above);
                if (v < free_lim)
                    rep.occ_class = CLASS_FREE;
                else if (v > occ_lim)
                    rep.occ_class = CLASS_OCCUPIED;
                rep.odds_val = v[15:0];
            end
            else
            begin
                rep.status = STATUS_REJECTED;
            end
        end
        else if (!in_grid(sc, sr) || !in_grid(ec, er))
        begin
            rep.status = STATUS_REJECTED;
        end
        else
        begin
            hit_inc = int'(map_cfg.hit_step);
            miss_inc = $signed(map_cfg.miss_step);
            dx = (ec > sc) ? ec - sc : sc - ec;
            dy = (er > sr) ? er - sr : sr - er;
            stx = (sc < ec) ? 1 : -1;
            sty = (sr < er) ? 1 : -1;
            err = dx - dy;
            c = sc;
            r = sr;
            walking = 1'b1;
            // Every cell short of the end takes the miss step; the end cell only a hit.
            while (walking)
            begin
                if (c == ec && r == er)
                begin
                    if (cmd.hit)
                        count += bump_cell(c, r, hit_inc);
                    walking = 1'b0;
                end
                else
                begin
                    count += bump_cell(c, r, miss_inc);
                    e2 = 2 * err;
                    if (e2 > -dy)
                    begin
                        err -= dy;
                        c += stx;
                    end
                    if (e2 < dx)
                    begin
                        err += dx;
                        r += sty;
                    end
                end
            end
            rep.changed = count[8:0];
        end
        return rep;
    endfunction

    // Waits until every expected result has arrived and the block has gone idle.
    task automatic wait_quiet();
        start <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        case (idx)
            REG_HIT_STEP:       map_cfg.hit_step = data[10:0];
            REG_MISS_STEP:      map_cfg.miss_step = data[11:0];
            REG_CLAMP_HIGH:     map_cfg.clamp_high = data[14:0];
            REG_CLAMP_LOW:      map_cfg.clamp_low = data;
            REG_GRID_WIDTH:     map_cfg.grid_width = data[8:0];
            REG_GRID_HEIGHT:    map_cfg.grid_height = data[8:0];
            REG_FREE_BELOW:     map_cfg.free_below = data;
            REG_OCCUPIED_ABOVE: map_cfg.occupied_above = data;
            default: ;
        endcase
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all eight registers once the block is idle; unused upper data bits carry junk.
    task automatic program_config(input cfg_t c);
        logic [15:0] junk;
        wait_quiet();
        junk = $urandom;
        cfg_write(REG_HIT_STEP, {junk[15:11], c.hit_step});
        junk = $urandom;
        cfg_write(REG_MISS_STEP, {junk[15:12], c.miss_step});
        junk = $urandom;
        cfg_write(REG_CLAMP_HIGH, {junk[15], c.clamp_high});
        cfg_write(REG_CLAMP_LOW, c.clamp_low);
        junk = $urandom;
        cfg_write(REG_GRID_WIDTH, {junk[15:9], c.grid_width});
        junk = $urandom;
        cfg_write(REG_GRID_HEIGHT, {junk[15:9], c.grid_height});
        cfg_write(REG_FREE_BELOW, c.free_below);
        cfg_write(REG_OCCUPIED_ABOVE, c.occupied_above);
    endtask

    // Holds the item on the ports until the block takes it, then records the expected result.
    task automatic send_cmd(input ray_cmd_t cmd);
        cell_report_t rep;
        operation <= cmd.op;
        start_col <= cmd.sc;
        start_row <= cmd.sr;
        end_col <= cmd.ec;
        end_row <= cmd.er;
        endpoint_is_hit <= cmd.hit;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rep = predict_cmd(cmd);
        awaited_reports.push_back(rep);
        if (cmd.op == OP_READ)
            reads_sent++;
        else
            traces_sent++;
        if (rep.status == STATUS_REJECTED)
            rejects_seen++;
        cells_changed += int'(rep.changed);
    endtask

    task automatic pace_sender();
        int gap;
        if (!no_idle)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                start <= 1'b0;
                gap = $urandom_range(idle_gap_max, 1);
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(24, 0);
            end
        end
    endtask

    function automatic ray_cmd_t trace_ray(input logic [7:0] sc, input logic [7:0] sr,
                                           input logic [7:0] ec, input logic [7:0] er,
                                           input logic hit);
        ray_cmd_t cmd;
        cmd.op = OP_TRACE;
        cmd.sc = sc;
        cmd.sr = sr;
        cmd.ec = ec;
        cmd.er = er;
        cmd.hit = hit;
        return cmd;
    endfunction

    function automatic ray_cmd_t cell_read(input logic [7:0] c, input logic [7:0] r);
        ray_cmd_t cmd;
        logic [31:0] noise;
        noise = $urandom;
        cmd.op = OP_READ;
        cmd.sc = c;
        cmd.sr = r;
        cmd.ec = noise[7:0];
        cmd.er = noise[15:8];
        cmd.hit = noise[16];
        return cmd;
    endfunction

    // Mostly inside a small window so that rays overlap, sometimes anywhere, now and then outside.
    function automatic logic [7:0] pick_coord(input int used);
        int sel;
        int top;
        int a;
        int b;
        int val;
        sel = $urandom_range(99);
        if (used == 0 || sel < 8)
        begin
            val = $urandom_range(255);
        end
        else
        begin
            top = used - 1;
            if (sel < 25)
            begin
                val = $urandom_range(top);
            end
            else
            begin
                a = win_lo % used;
                b = a + win_span;
                if (b > top)
                    b = top;
                val = $urandom_range(b, a);
            end
        end
        return val[7:0];
    endfunction

    function automatic ray_cmd_t random_cmd();
        ray_cmd_t cmd;
        cmd.op = ($urandom_range(99) < 35) ? OP_READ : OP_TRACE;
        cmd.sc = pick_coord(cols_in_use());
        cmd.sr = pick_coord(rows_in_use());
        cmd.ec = pick_coord(cols_in_use());
        cmd.er = pick_coord(rows_in_use());
        cmd.hit = ($urandom_range(99) < 75);
        return cmd;
    endfunction

    function automatic cfg_t random_config(input int mode);
        cfg_t c;
        int t;
        logic [127:0] raw;
        c = map_cfg;
        case (mode)
            1:
            begin
                c.hit_step = $urandom_range(1) ? 11'd2047 : 11'd0;
                c.miss_step = $urandom_range(1) ? 12'h800 : 12'h000;
                c.clamp_high = $urandom_range(1) ? 15'd32767 : 15'd0;
                c.clamp_low = $urandom_range(1) ? 16'h8000 : 16'h0000;
                c.grid_width = $urandom_range(1) ? 9'd256 : 9'd1;
                c.grid_height = $urandom_range(1) ? 9'd256 : 9'd1;
                c.free_below = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                c.occupied_above = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            end
            2:
            begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                c = raw[103:0];
            end
            default:
            begin
                t = $urandom_range(400, 100);
                c.hit_step = t[10:0];
                t = $urandom_range(200, 40);
                t = -t;
                c.miss_step = t[11:0];
                t = $urandom_range(2000, 300);
                c.clamp_high = t[14:0];
                t = $urandom_range(2000, 300);
                t = -t;
                c.clamp_low = t[15:0];
                c.grid_width = 9'd256;
                c.grid_height = 9'd256;
                t = $urandom_range(600, 0);
                t = -t;
                c.free_below = t[15:0];
                t = $urandom_range(600, 0);
                c.occupied_above = t[15:0];
                if (mode == 3)
                begin
                    t = $urandom_range(40, 1);
                    c.grid_width = t[8:0];
                    t = $urandom_range(40, 1);
                    c.grid_height = t[8:0];
                end
            end
        endcase
        return c;
    endfunction

    task automatic test_reset_defaults();
        send_cmd(cell_read(8'd5, 8'd5));
        // A zero-length ray touches only its end cell, and that only when it is a hit.
        send_cmd(trace_ray(8'd5, 8'd5, 8'd5, 8'd5, 1'b0));
        send_cmd(trace_ray(8'd5, 8'd5, 8'd5, 8'd5, 1'b1));
        send_cmd(trace_ray(8'd0, 8'd0, 8'd255, 8'd255, 1'b1));
        send_cmd(trace_ray(8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
        send_cmd(trace_ray(8'd10, 8'd3, 8'd2, 8'd3, 1'b1));
        send_cmd(trace_ray(8'd7, 8'd20, 8'd9, 8'd1, 1'b1));
        send_cmd(cell_read(8'd5, 8'd5));
    endtask

    task automatic test_clamping();
        cfg_t c;
        c = map_cfg;
        c.clamp_high = 15'd300;
        c.clamp_low = -16'sd300;
        program_config(c);
        // The second hit finds the cell at its bound, so nothing is counted.
        send_cmd(trace_ray(8'd5, 8'd5, 8'd5, 8'd5, 1'b1));
        send_cmd(trace_ray(8'd5, 8'd5, 8'd5, 8'd5, 1'b1));
        repeat (3) send_cmd(trace_ray(8'd1, 8'd5, 8'd5, 8'd5, 1'b0));
        send_cmd(cell_read(8'd2, 8'd5));
        // With the lower bound above the upper one, the lower bound has the last word.
        c.clamp_high = 15'd0;
        c.clamp_low = 16'sd256;
        program_config(c);
        send_cmd(trace_ray(8'd40, 8'd40, 8'd40, 8'd40, 1'b1));
        send_cmd(cell_read(8'd40, 8'd40));
    endtask

    task automatic test_grid_limits();
        cfg_t c;
        c = map_cfg;
        c.clamp_high = 15'd1280;
        c.clamp_low = -16'sd1280;
        c.grid_width = 9'd12;
        c.grid_height = 9'd5;
        program_config(c);
        send_cmd(cell_read(8'd11, 8'd4));
        send_cmd(cell_read(8'd12, 8'd0));
        send_cmd(cell_read(8'd0, 8'd5));
        send_cmd(trace_ray(8'd0, 8'd0, 8'd12, 8'd4, 1'b1));
        send_cmd(trace_ray(8'd11, 8'd4, 8'd0, 8'd0, 1'b1));
        c.grid_width = 9'd0;
        program_config(c);
        send_cmd(trace_ray(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        // Sizes beyond the memory side fall back to the full grid.
        c.grid_width = 9'd511;
        c.grid_height = 9'd300;
        program_config(c);
        send_cmd(trace_ray(8'd255, 8'd255, 8'd250, 8'd240, 1'b1));
    endtask

    task automatic test_threshold_extremes();
        cfg_t c;
        c.hit_step = 11'd2047;
        c.miss_step = 12'h800;
        c.clamp_high = 15'd32767;
        c.clamp_low = 16'h8000;
        c.grid_width = 9'd256;
        c.grid_height = 9'd256;
        c.free_below = 16'h8000;
        c.occupied_above = 16'h7FFF;
        program_config(c);
        send_cmd(trace_ray(8'd90, 8'd100, 8'd100, 8'd100, 1'b1));
        send_cmd(cell_read(8'd100, 8'd100));
        c.free_below = 16'h7FFF;
        c.occupied_above = 16'h8000;
        program_config(c);
        send_cmd(cell_read(8'd95, 8'd100));
    endtask

    task automatic test_random_mapping();
        cfg_t c;
        int phase;
        int n;
        int mode;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                1, 5: mode = 3;
                2: mode = 1;
                4: mode = 2;
                default: mode = 0;
            endcase
            c = random_config(mode);
            // Reconfiguring between phases also makes the sender hold off until all results are in.
            program_config(c);
            win_lo = $urandom_range(240);
            win_span = $urandom_range(15, 3);
            no_idle = (phase == 3);
            idle_gap_max = (phase == 1) ? 40 : 8;
            burst_left = 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_cmd(random_cmd());
                pace_sender();
            end
        end
    endtask

    // Each result is taken at the edge that ends its strobe cycle.
    always @(posedge clk)
    begin
        cell_report_t want;
        if (rst_n && done)
        begin
            if (awaited_reports.size() == 0)
            begin
                report_mismatch("result strobe with no transfer waiting for it");
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (cell_log_odds !== want.odds_val || occupancy_class !== want.occ_class ||
                    cells_updated !== want.changed || status !== want.status)
                begin
                    report_mismatch($sformatf(
                        "got odds %0d class %0d changed %0d status %0d, want %0d %0d %0d %0d",
                        cell_log_odds, occupancy_class, cells_updated, status,
                        want.odds_val, want.occ_class, want.changed, want.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SIDE*SIDE; i++)
            odds_map[i] = '0;
        map_cfg.hit_step = 11'd217;
        map_cfg.miss_step = -12'sd104;
        map_cfg.clamp_high = 15'd1280;
        map_cfg.clamp_low = -16'sd1280;
        map_cfg.grid_width = 9'd256;
        map_cfg.grid_height = 9'd256;
        map_cfg.free_below = -16'sd281;
        map_cfg.occupied_above = 16'sd158;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_clamping();
        test_grid_limits();
        test_threshold_extremes();
        test_random_mapping();

        wait_quiet();
        repeat (16) @(posedge clk);
        if (awaited_reports.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_reports.size()));
        $display("Covered %0d ray traces and %0d cell reads, %0d rejected as off the grid.",
                 traces_sent, reads_sent, rejects_seen);
        $display("%0d cell changes over directed checks and %0d random register phases.",
                 cells_changed, RANDOM_PHASES);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
